### rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes, status codes, result limits and the control word that
// travels with each request down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int RES_WIDTH = 24;
   localparam int QUO_BITS  = RES_WIDTH + 1;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_DIST = 3'd4;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_DBZ = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   localparam logic [RES_WIDTH-1:0] RES_MAX_V = {1'b0, {(RES_WIDTH-1){1'b1}}};
   localparam logic [RES_WIDTH-1:0] RES_MIN_V = {1'b1, {(RES_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [2:0] op;
      logic       neg_re;
      logic       neg_im;
      logic       dbz;
      logic       ovf_re;
      logic       ovf_im;
   } cau_ctl_type;

endpackage

### rtl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit core
// Add, subtract, multiply, divide and distance on signed fixed point complex
// operands, with rounding, saturation and status.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while the response side does not
// hold the pipeline, and returns one response per request, in order. It has
// three front stages for products, sums and operand preparation, a chain of
// NUM_CELLS cells that each resolve, at their bit position, one quotient bit
// of both divide lanes, one square root bit, or both, and the output register.
// NUM_CELLS is the larger of 25 quotient bits and IN_WIDTH + 1 root bits.
// Every stage stalls only when the stage after it is full and held.
module complex_arithmetic_unit_core #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_type,
   input  logic signed [IN_WIDTH-1:0]     req_a_re,
   input  logic signed [IN_WIDTH-1:0]     req_a_im,
   input  logic signed [IN_WIDTH-1:0]     req_b_re,
   input  logic signed [IN_WIDTH-1:0]     req_b_im,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cau_pkg::RES_WIDTH-1:0]  rsp_res_re,
   output logic [cau_pkg::RES_WIDTH-1:0]  rsp_res_im,
   output logic [1:0]                     rsp_status
);
   import cau_pkg::*;

   localparam int MAG_W     = (2*IN_WIDTH > QUO_BITS) ? 2*IN_WIDTH : QUO_BITS;
   localparam int DVD_W     = 2*IN_WIDTH + FRAC_BITS + 2;
   localparam int DSR_W     = 2*IN_WIDTH + 1;
   localparam int ROOT_W    = IN_WIDTH + 1;
   localparam int RAD_W     = 2*(IN_WIDTH+1) + 1;
   localparam int NUM_CELLS = (QUO_BITS > ROOT_W) ? QUO_BITS : ROOT_W;

   logic              lnk_valid  [NUM_CELLS+1];
   logic              lnk_ready  [NUM_CELLS+1];
   cau_ctl_type       lnk_ctl    [NUM_CELLS+1];
   logic [MAG_W-1:0]  lnk_q_re   [NUM_CELLS+1];
   logic [MAG_W-1:0]  lnk_q_im   [NUM_CELLS+1];
   logic [DVD_W-1:0]  lnk_rem_re [NUM_CELLS+1];
   logic [DVD_W-1:0]  lnk_rem_im [NUM_CELLS+1];
   logic [DSR_W-1:0]  lnk_dsr    [NUM_CELLS+1];
   logic [ROOT_W-1:0] lnk_root   [NUM_CELLS+1];
   logic [RAD_W-1:0]  lnk_rad    [NUM_CELLS+1];

   assign lnk_root[0] = '0;

   cau_front #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_op      (req_type),
      .in_a_re    (req_a_re),
      .in_a_im    (req_a_im),
      .in_b_re    (req_b_re),
      .in_b_im    (req_b_im),
      .out_valid  (lnk_valid[0]),
      .out_ready  (lnk_ready[0]),
      .out_ctl    (lnk_ctl[0]),
      .out_q_re   (lnk_q_re[0]),
      .out_q_im   (lnk_q_im[0]),
      .out_rem_re (lnk_rem_re[0]),
      .out_rem_im (lnk_rem_im[0]),
      .out_dsr    (lnk_dsr[0]),
      .out_rad    (lnk_rad[0])
   );

   generate
      for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
         cau_cell #(
            .IN_WIDTH  (IN_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .BIT       (NUM_CELLS - 1 - i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (lnk_valid[i]),
            .in_ready   (lnk_ready[i]),
            .in_ctl     (lnk_ctl[i]),
            .in_q_re    (lnk_q_re[i]),
            .in_q_im    (lnk_q_im[i]),
            .in_rem_re  (lnk_rem_re[i]),
            .in_rem_im  (lnk_rem_im[i]),
            .in_dsr     (lnk_dsr[i]),
            .in_root    (lnk_root[i]),
            .in_rad     (lnk_rad[i]),
            .out_valid  (lnk_valid[i+1]),
            .out_ready  (lnk_ready[i+1]),
            .out_ctl    (lnk_ctl[i+1]),
            .out_q_re   (lnk_q_re[i+1]),
            .out_q_im   (lnk_q_im[i+1]),
            .out_rem_re (lnk_rem_re[i+1]),
            .out_rem_im (lnk_rem_im[i+1]),
            .out_dsr    (lnk_dsr[i+1]),
            .out_root   (lnk_root[i+1]),
            .out_rad    (lnk_rad[i+1])
         );
      end
   endgenerate

   cau_back #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lnk_valid[NUM_CELLS]),
      .in_ready   (lnk_ready[NUM_CELLS]),
      .in_ctl     (lnk_ctl[NUM_CELLS]),
      .in_q_re    (lnk_q_re[NUM_CELLS]),
      .in_q_im    (lnk_q_im[NUM_CELLS]),
      .in_root    (lnk_root[NUM_CELLS]),
      .in_rad     (lnk_rad[NUM_CELLS]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_res_re (rsp_res_re),
      .rsp_res_im (rsp_res_im),
      .rsp_status (rsp_status)
   );

endmodule

### rtl/cau_front.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three pipeline stages: products and differences, sums, then sign and
// magnitude preparation that loads the divide and square root cell chain.
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 8,
   localparam int MAG_W = (2*IN_WIDTH > cau_pkg::QUO_BITS) ? 2*IN_WIDTH : cau_pkg::QUO_BITS,
   localparam int DVD_W = 2*IN_WIDTH + FRAC_BITS + 2,
   localparam int DSR_W = 2*IN_WIDTH + 1,
   localparam int RAD_W = 2*(IN_WIDTH+1) + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [2:0]                  in_op,
   input  logic signed [IN_WIDTH-1:0]  in_a_re,
   input  logic signed [IN_WIDTH-1:0]  in_a_im,
   input  logic signed [IN_WIDTH-1:0]  in_b_re,
   input  logic signed [IN_WIDTH-1:0]  in_b_im,
   output logic                        out_valid,
   input  logic                        out_ready,
   output cau_pkg::cau_ctl_type        out_ctl,
   output logic [MAG_W-1:0]            out_q_re,
   output logic [MAG_W-1:0]            out_q_im,
   output logic [DVD_W-1:0]            out_rem_re,
   output logic [DVD_W-1:0]            out_rem_im,
   output logic [DSR_W-1:0]            out_dsr,
   output logic [RAD_W-1:0]            out_rad
);
   import cau_pkg::*;

   localparam int W     = IN_WIDTH;
   localparam int CMP_W = DVD_W + QUO_BITS;
   localparam logic [2*W+1:0] HALF = ((2*W+2)'(1) << FRAC_BITS) >> 1;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   // Stage 1: products and sums.
   logic signed [W:0]       dif_re, dif_im, sre_in, sim_in;
   logic signed [2*W+1:0]   dre_sq, dim_sq;
   logic signed [2*W-1:0]   prr_in, pii_in, pir_in, pri_in, brsq_in, bisq_in;
   logic [2:0]              op1_ff;
   logic signed [W:0]       sre1_ff, sim1_ff;
   logic signed [2*W-1:0]   prr1_ff, pii1_ff, pir1_ff, pri1_ff;
   logic [2*W-1:0]          brsq1_ff, bisq1_ff;
   logic [2*W:0]            drsq1_ff, disq1_ff;

   assign dif_re  = in_a_re - in_b_re;
   assign dif_im  = in_a_im - in_b_im;
   assign sre_in  = (in_op == OP_SUB) ? dif_re : in_a_re + in_b_re;
   assign sim_in  = (in_op == OP_SUB) ? dif_im : in_a_im + in_b_im;
   assign dre_sq  = dif_re * dif_re;
   assign dim_sq  = dif_im * dif_im;
   assign prr_in  = in_a_re * in_b_re;
   assign pii_in  = in_a_im * in_b_im;
   assign pir_in  = in_a_im * in_b_re;
   assign pri_in  = in_a_re * in_b_im;
   assign brsq_in = in_b_re * in_b_re;
   assign bisq_in = in_b_im * in_b_im;

   assign rdy1     = !v1_ff || rdy2;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy3     = !v3_ff || out_ready;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= in_valid;
      end
      if (rdy1) begin
         op1_ff   <= in_op;
         sre1_ff  <= sre_in;
         sim1_ff  <= sim_in;
         prr1_ff  <= prr_in;
         pii1_ff  <= pii_in;
         pir1_ff  <= pir_in;
         pri1_ff  <= pri_in;
         brsq1_ff <= $unsigned(brsq_in);
         bisq1_ff <= $unsigned(bisq_in);
         drsq1_ff <= $unsigned(dre_sq[2*W:0]);
         disq1_ff <= $unsigned(dim_sq[2*W:0]);
      end
   end

   // Stage 2: real and imaginary combinations.
   logic signed [2*W:0] mre_in, mim_in, nre_in, nim_in;
   logic [2*W-1:0]      d_in;
   logic [2*W+1:0]      s_in;
   logic [2:0]          op2_ff;
   logic signed [W:0]   sre2_ff, sim2_ff;
   logic signed [2*W:0] mre2_ff, mim2_ff, nre2_ff, nim2_ff;
   logic [2*W-1:0]      d2_ff;
   logic [2*W+1:0]      s2_ff;

   assign mre_in = prr1_ff - pii1_ff;
   assign mim_in = pir1_ff + pri1_ff;
   assign nre_in = prr1_ff + pii1_ff;
   assign nim_in = pir1_ff - pri1_ff;
   assign d_in   = brsq1_ff + bisq1_ff;
   assign s_in   = {1'b0, drsq1_ff} + {1'b0, disq1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2) begin
         op2_ff  <= op1_ff;
         sre2_ff <= sre1_ff;
         sim2_ff <= sim1_ff;
         mre2_ff <= mre_in;
         mim2_ff <= mim_in;
         nre2_ff <= nre_in;
         nim2_ff <= nim_in;
         d2_ff   <= d_in;
         s2_ff   <= s_in;
      end
   end

   // Stage 3: signs, magnitudes, rounding and divide operands.
   logic signed [W:0]   sre_neg, sim_neg;
   logic signed [2*W:0] mre_neg, mim_neg, nre_neg, nim_neg;
   logic [W:0]          sre_abs, sim_abs;
   logic [2*W:0]        mre_abs, mim_abs, nre_abs, nim_abs;
   logic [2*W+1:0]      rnd_re, rnd_im;
   logic [DSR_W-1:0]    dsr;
   logic [DVD_W-1:0]    dvd_re, dvd_im;
   logic [CMP_W-1:0]    lim;
   cau_ctl_type         ctl_in;
   logic [MAG_W-1:0]    q_re_in, q_im_in;
   logic [DVD_W-1:0]    rem_re_in, rem_im_in;

   assign sre_neg = -sre2_ff;
   assign sim_neg = -sim2_ff;
   assign mre_neg = -mre2_ff;
   assign mim_neg = -mim2_ff;
   assign nre_neg = -nre2_ff;
   assign nim_neg = -nim2_ff;
   assign sre_abs = sre2_ff[W]   ? $unsigned(sre_neg) : $unsigned(sre2_ff);
   assign sim_abs = sim2_ff[W]   ? $unsigned(sim_neg) : $unsigned(sim2_ff);
   assign mre_abs = mre2_ff[2*W] ? $unsigned(mre_neg) : $unsigned(mre2_ff);
   assign mim_abs = mim2_ff[2*W] ? $unsigned(mim_neg) : $unsigned(mim2_ff);
   assign nre_abs = nre2_ff[2*W] ? $unsigned(nre_neg) : $unsigned(nre2_ff);
   assign nim_abs = nim2_ff[2*W] ? $unsigned(nim_neg) : $unsigned(nim2_ff);
   assign rnd_re  = ({1'b0, mre_abs} + HALF) >> FRAC_BITS;
   assign rnd_im  = ({1'b0, mim_abs} + HALF) >> FRAC_BITS;
   assign dsr     = {d2_ff, 1'b0};
   assign dvd_re  = (DVD_W'(nre_abs) << (FRAC_BITS + 1)) + DVD_W'(d2_ff);
   assign dvd_im  = (DVD_W'(nim_abs) << (FRAC_BITS + 1)) + DVD_W'(d2_ff);
   assign lim     = CMP_W'(dsr) << QUO_BITS;

   always_comb begin
      ctl_in    = '0;
      ctl_in.op = op2_ff;
      q_re_in   = '0;
      q_im_in   = '0;
      rem_re_in = '0;
      rem_im_in = '0;
      case (op2_ff)
         OP_ADD, OP_SUB: begin
            ctl_in.neg_re = sre2_ff[W];
            ctl_in.neg_im = sim2_ff[W];
            q_re_in       = MAG_W'(sre_abs);
            q_im_in       = MAG_W'(sim_abs);
         end
         OP_MUL: begin
            ctl_in.neg_re = mre2_ff[2*W];
            ctl_in.neg_im = mim2_ff[2*W];
            q_re_in       = MAG_W'(rnd_re);
            q_im_in       = MAG_W'(rnd_im);
         end
         OP_DIV: begin
            ctl_in.dbz    = (d2_ff == '0);
            ctl_in.neg_re = nre2_ff[2*W];
            ctl_in.neg_im = nim2_ff[2*W];
            ctl_in.ovf_re = (CMP_W'(dvd_re) >= lim);
            ctl_in.ovf_im = (CMP_W'(dvd_im) >= lim);
            rem_re_in     = dvd_re;
            rem_im_in     = dvd_im;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
      if (rdy3) begin
         out_ctl    <= ctl_in;
         out_q_re   <= q_re_in;
         out_q_im   <= q_im_in;
         out_rem_re <= rem_re_in;
         out_rem_im <= rem_im_in;
         out_dsr    <= dsr;
         out_rad    <= RAD_W'(s2_ff);
      end
   end

   assign out_valid = v3_ff;

endmodule

### rtl/cau_cell.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit cell
// One restoring step of both quotients and one step of the square root, each
// where the bit position that this cell owns lies in its range, followed by a pipeline register.
// ----------------------------------------------------------------------------
module cau_cell #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 8,
   parameter int BIT       = 0,
   localparam int MAG_W  = (2*IN_WIDTH > cau_pkg::QUO_BITS) ? 2*IN_WIDTH : cau_pkg::QUO_BITS,
   localparam int DVD_W  = 2*IN_WIDTH + FRAC_BITS + 2,
   localparam int DSR_W  = 2*IN_WIDTH + 1,
   localparam int ROOT_W = IN_WIDTH + 1,
   localparam int RAD_W  = 2*(IN_WIDTH+1) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cau_pkg::cau_ctl_type in_ctl,
   input  logic [MAG_W-1:0]     in_q_re,
   input  logic [MAG_W-1:0]     in_q_im,
   input  logic [DVD_W-1:0]     in_rem_re,
   input  logic [DVD_W-1:0]     in_rem_im,
   input  logic [DSR_W-1:0]     in_dsr,
   input  logic [ROOT_W-1:0]    in_root,
   input  logic [RAD_W-1:0]     in_rad,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cau_pkg::cau_ctl_type out_ctl,
   output logic [MAG_W-1:0]     out_q_re,
   output logic [MAG_W-1:0]     out_q_im,
   output logic [DVD_W-1:0]     out_rem_re,
   output logic [DVD_W-1:0]     out_rem_im,
   output logic [DSR_W-1:0]     out_dsr,
   output logic [ROOT_W-1:0]    out_root,
   output logic [RAD_W-1:0]     out_rad
);
   import cau_pkg::*;

   localparam int  CMP_W   = DVD_W + QUO_BITS;
   localparam bit  DO_DIV  = (BIT < QUO_BITS);
   localparam bit  DO_SQRT = (BIT < ROOT_W);

   logic              valid_ff;
   logic [CMP_W-1:0]  shifted, diff_re, diff_im;
   logic              ge_re, ge_im, div_act;
   logic [RAD_W-1:0]  trial;
   logic              ge_rad;
   logic [MAG_W-1:0]  q_re_in, q_im_in;
   logic [DVD_W-1:0]  rem_re_in, rem_im_in;
   logic [ROOT_W-1:0] root_in;
   logic [RAD_W-1:0]  rad_in;

   assign shifted = CMP_W'(in_dsr) << BIT;
   assign diff_re = CMP_W'(in_rem_re) - shifted;
   assign diff_im = CMP_W'(in_rem_im) - shifted;
   assign ge_re   = CMP_W'(in_rem_re) >= shifted;
   assign ge_im   = CMP_W'(in_rem_im) >= shifted;
   assign div_act = DO_DIV && (in_ctl.op == OP_DIV);

   assign trial  = (RAD_W'(in_root) << (BIT + 1)) + (RAD_W'(1) << (2*BIT));
   assign ge_rad = DO_SQRT && (in_rad >= trial);

   always_comb begin
      q_re_in   = in_q_re;
      q_im_in   = in_q_im;
      rem_re_in = in_rem_re;
      rem_im_in = in_rem_im;
      root_in   = in_root;
      rad_in    = in_rad;
      if (div_act && ge_re) begin
         rem_re_in = DVD_W'(diff_re);
         q_re_in   = in_q_re | (MAG_W'(1) << BIT);
      end
      if (div_act && ge_im) begin
         rem_im_in = DVD_W'(diff_im);
         q_im_in   = in_q_im | (MAG_W'(1) << BIT);
      end
      if (ge_rad) begin
         rad_in  = in_rad - trial;
         root_in = in_root | (ROOT_W'(1) << BIT);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         out_ctl    <= in_ctl;
         out_q_re   <= q_re_in;
         out_q_im   <= q_im_in;
         out_rem_re <= rem_re_in;
         out_rem_im <= rem_im_in;
         out_dsr    <= in_dsr;
         out_root   <= root_in;
         out_rad    <= rad_in;
      end
   end

   assign out_valid = valid_ff;

   generate
      if (DO_DIV) begin : g_chk
         // The real partial remainder stays below the divisor at this bit weight.
         assert property (@(posedge clock) disable iff (reset)
            out_valid && out_ctl.op == OP_DIV && !out_ctl.dbz && !out_ctl.ovf_re
            |-> CMP_W'(out_rem_re) < (CMP_W'(out_dsr) << BIT))
            else $error("Real remainder is not reduced below the shifted divisor.");
      end
   endgenerate

endmodule

### rtl/cau_back.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Rounds the square root, applies signs, saturates to the result range,
// sets the status and holds the result in the output register.
// ----------------------------------------------------------------------------
module cau_back #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 8,
   localparam int MAG_W  = (2*IN_WIDTH > cau_pkg::QUO_BITS) ? 2*IN_WIDTH : cau_pkg::QUO_BITS,
   localparam int ROOT_W = IN_WIDTH + 1,
   localparam int RAD_W  = 2*(IN_WIDTH+1) + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  cau_pkg::cau_ctl_type            in_ctl,
   input  logic [MAG_W-1:0]                in_q_re,
   input  logic [MAG_W-1:0]                in_q_im,
   input  logic [ROOT_W-1:0]               in_root,
   input  logic [RAD_W-1:0]                in_rad,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cau_pkg::RES_WIDTH-1:0]   rsp_res_re,
   output logic [cau_pkg::RES_WIDTH-1:0]   rsp_res_im,
   output logic [1:0]                      rsp_status
);
   import cau_pkg::*;

   localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(RES_MAX_V);
   localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(RES_MIN_V);

   logic                 valid_ff;
   logic [RES_WIDTH-1:0] re_ff, im_ff;
   logic [1:0]           status_ff;
   logic                 rad_gt;
   logic [ROOT_W:0]      root_rnd;
   logic [MAG_W-1:0]     mag_re, mag_im, sgn_re, sgn_im;
   logic                 sat_re, sat_im;
   logic [RES_WIDTH-1:0] re_in, im_in;
   logic [1:0]           status_in;

   assign rad_gt   = in_rad > RAD_W'(in_root);
   assign root_rnd = (ROOT_W+1)'(in_root) + (ROOT_W+1)'(rad_gt);
   assign mag_re   = (in_ctl.op == OP_DIST) ? MAG_W'(root_rnd) : in_q_re;
   assign mag_im   = in_q_im;
   assign sgn_re   = in_ctl.neg_re ? (~mag_re + 1'b1) : mag_re;
   assign sgn_im   = in_ctl.neg_im ? (~mag_im + 1'b1) : mag_im;
   assign sat_re   = in_ctl.ovf_re || (in_ctl.neg_re ? (mag_re > NEG_LIM) : (mag_re > POS_LIM));
   assign sat_im   = in_ctl.ovf_im || (in_ctl.neg_im ? (mag_im > NEG_LIM) : (mag_im > POS_LIM));

   always_comb begin
      if (in_ctl.dbz) begin
         re_in     = '0;
         im_in     = '0;
         status_in = ST_DBZ;
      end else begin
         re_in     = sat_re ? (in_ctl.neg_re ? RES_MIN_V : RES_MAX_V) : sgn_re[RES_WIDTH-1:0];
         im_in     = sat_im ? (in_ctl.neg_im ? RES_MIN_V : RES_MAX_V) : sgn_im[RES_WIDTH-1:0];
         status_in = (sat_re || sat_im) ? ST_SAT : ST_OK;
      end
   end

   assign in_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         re_ff     <= re_in;
         im_ff     <= im_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_res_re = re_ff;
   assign rsp_res_im = im_ff;
   assign rsp_status = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DBZ |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("Divide by zero result carries nonzero parts.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SAT
      |-> rsp_res_re == RES_MAX_V || rsp_res_re == RES_MIN_V
       || rsp_res_im == RES_MAX_V || rsp_res_im == RES_MIN_V)
      else $error("Saturated status without a clamped part.");

   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && in_ctl.op != OP_DIV |=> rsp_status != ST_DBZ)
      else $error("Divide by zero status on an operation that does not divide.");

endmodule

### tb/complex_arithmetic_unit_core_test.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit core test
// Drives requests from a directed table and then random requests, and lets
// both handshake sides idle at random. It compares every response, field by
// field and in order, with the result that a behavioral model of the unit
// works out for each request.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   localparam int IW = 16;
   localparam int FB = 8;
   localparam int LATENCY = 29;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int NUM_RANDOM = 530;
   localparam int NUM_DIRECTED = 22;
   localparam logic [2:0] OP_BAD = 3'd7;

   typedef struct {
      logic [2:0] op;
      logic signed [IW-1:0] ar, ai, br, bi;
      bit known;
      logic [RES_WIDTH-1:0] re, im;
      logic [1:0] st;
   } stim_row_type;

   typedef struct {
      logic [RES_WIDTH-1:0] re, im;
      logic [1:0] st;
   } cau_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_type = OP_ADD;
   logic signed [IW-1:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [RES_WIDTH-1:0] rsp_res_re, rsp_res_im;
   logic [1:0] rsp_status;

   cau_result_type pending_results[$];
   int errors = 0;
   longint cycle_count = 0;
   bit stim_done = 1'b0;
   bit quiet_phase = 1'b0;
   bit long_hold = 1'b0;
   stim_row_type table_rows[NUM_DIRECTED];

   complex_arithmetic_unit_core #(.IN_WIDTH(IW), .FRAC_BITS(FB)) dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift_q(longint p);
      longint mag;
      mag = (p < 0) ? -p : p;
      mag = (mag + (64'sd1 <<< (FB - 1))) >>> FB;
      return (p < 0) ? -mag : mag;
   endfunction

   function automatic longint round_quotient(longint n, longint d);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
   endfunction

   function automatic longint nearest_root(longint s);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= s)
            r = r + (64'sd1 <<< b);
      end
      if (s - r * r > r)
         r++;
      return r;
   endfunction

   function automatic longint clip_part(longint v, ref bit clipped);
      longint hi, lo;
      hi = (64'sd1 <<< (RES_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clipped = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clipped = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic cau_result_type complex_result(logic [2:0] op,
         logic signed [IW-1:0] a_re, a_im, b_re, b_im);
      cau_result_type r;
      longint ar, ai, br, bi, re, im, d, dr, di;
      bit clipped;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      re = 0;
      im = 0;
      clipped = 1'b0;
      r.st = ST_OK;
      case (op)
         OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         OP_MUL: begin
            re = round_shift_q(ar * br - ai * bi);
            im = round_shift_q(ai * br + ar * bi);
         end
         OP_DIV: begin
            if (br == 0 && bi == 0) begin
               r.st = ST_DBZ;
            end else begin
               d = br * br + bi * bi;
               re = round_quotient((ar * br + ai * bi) * (64'sd1 <<< FB), d);
               im = round_quotient((ai * br - ar * bi) * (64'sd1 <<< FB), d);
            end
         end
         OP_DIST: begin
            dr = ar - br;
            di = ai - bi;
            re = nearest_root(dr * dr + di * di);
         end
         default: ;
      endcase
      re = clip_part(re, clipped);
      im = clip_part(im, clipped);
      if (clipped && r.st == ST_OK)
         r.st = ST_SAT;
      r.re = re[RES_WIDTH-1:0];
      r.im = im[RES_WIDTH-1:0];
      return r;
   endfunction

   function automatic stim_row_type row(logic [2:0] op, int ar, int ai, int br, int bi,
         bit known = 1'b0, int re = 0, int im = 0, logic [1:0] st = ST_OK);
      stim_row_type s;
      s.op = op;
      s.ar = IW'(ar);
      s.ai = IW'(ai);
      s.br = IW'(br);
      s.bi = IW'(bi);
      s.known = known;
      s.re = RES_WIDTH'(re);
      s.im = RES_WIDTH'(im);
      s.st = st;
      return s;
   endfunction

   function automatic logic signed [IW-1:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3: return IW'($urandom_range(0, 1023) - 512);
         default: return IW'($urandom);
      endcase
   endfunction

   task automatic send_request(logic [2:0] op, logic signed [IW-1:0] ar, ai, br, bi);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_results.push_back(complex_result(op, ar, ai, br, bi));
   endtask

   initial begin
      cau_result_type chk;
      table_rows = '{
         row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, ST_OK),
         row(OP_ADD, 32767, 32767, 32767, 32767, 1, 65534, 65534, ST_OK),
         row(OP_ADD, -32768, -32768, -32768, -32768, 1, -65536, -65536, ST_OK),
         row(OP_SUB, 32767, -32768, -32768, 32767, 1, 65535, -65535, ST_OK),
         row(OP_SUB, -32768, 100, 32767, 100, 1, -65535, 0, ST_OK),
         row(OP_MUL, 256, 0, 256, 0, 1, 256, 0, ST_OK),
         row(OP_MUL, -32768, -32768, -32768, 32767),
         row(OP_MUL, -32768, 0, -32768, 0, 1, 4194304, 0, ST_OK),
         row(OP_MUL, 32767, -32768, 32767, 32767),
         row(OP_MUL, 1, 0, 128, 0),
         row(OP_MUL, -1, 0, 128, 0),
         row(OP_DIV, 1000, -77, 0, 0, 1, 0, 0, ST_DBZ),
         row(OP_DIV, -32768, -32768, 0, 1, 1, -8388608, 8388607, ST_SAT),
         row(OP_DIV, -32768, -32768, 0, -1),
         row(OP_DIV, 512, 256, 256, 0, 1, 512, 256, ST_OK),
         row(OP_DIV, 32767, 32767, -32768, -32768),
         row(OP_DIV, 1, 0, 3, 0),
         row(OP_DIST, 0, 0, 768, 1024, 1, 1280, 0, ST_OK),
         row(OP_DIST, 32767, 32767, -32768, -32768),
         row(OP_DIST, 5, 5, 5, 5, 1, 0, 0, ST_OK),
         row(3'd5, 100, 200, 300, 400, 1, 0, 0, ST_OK),
         row(OP_BAD, -1, -1, -1, -1, 1, 0, 0, ST_OK)
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (table_rows[i]) begin
         if (table_rows[i].known) begin
            chk = complex_result(table_rows[i].op, table_rows[i].ar, table_rows[i].ai,
                                 table_rows[i].br, table_rows[i].bi);
            if (chk.re !== table_rows[i].re) begin
               $error("row %0d res_re expected %0h actual %0h", i, table_rows[i].re, chk.re);
               errors++;
            end
            if (chk.im !== table_rows[i].im) begin
               $error("row %0d res_im expected %0h actual %0h", i, table_rows[i].im, chk.im);
               errors++;
            end
            if (chk.st !== table_rows[i].st) begin
               $error("row %0d status expected %0d actual %0d", i, table_rows[i].st, chk.st);
               errors++;
            end
         end
         send_request(table_rows[i].op, table_rows[i].ar, table_rows[i].ai,
                      table_rows[i].br, table_rows[i].bi);
      end
      long_hold = 1'b1;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM - 80)
            quiet_phase = 1'b1;
         send_request($urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4)),
                      random_operand(), random_operand(), random_operand(),
                      random_operand());
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (long_hold);
      while (!quiet_phase) begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (120) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   initial begin
      wait (!reset);
      @(posedge clock);
      rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      cau_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_re !== want.re) begin
               $error("res_re expected %0h actual %0h", want.re, rsp_res_re);
               errors++;
            end
            if (rsp_res_im !== want.im) begin
               $error("res_im expected %0h actual %0h", want.im, rsp_res_im);
               errors++;
            end
            if (rsp_status !== want.st) begin
               $error("status expected %0d actual %0d", want.st, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done && pending_results.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("complex_arithmetic_unit_core test passed");
      else
         $display("complex_arithmetic_unit_core test failed");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("complex_arithmetic_unit_core test failed");
            $finish;
         end
      end
   end

endmodule
